FILE: rtl/tma_pkg.sv
// shared constants and types for the trimmed mean averager
package tma_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int IN_BITS         = 12;
    localparam int OUT_BITS        = 12;
    localparam int CNT_BITS        = 7;
    localparam int IN_TDATA_BITS   = 16;
    localparam int OUT_TDATA_BITS  = 16;
    localparam int CFG_DATA_BITS   = 8;

    localparam logic [CNT_BITS-1:0] BATCH_RESET = 7'd100;
    localparam logic [CNT_BITS-1:0] BATCH_MIN   = 7'd3;
    localparam logic [CNT_BITS-1:0] DIV_OFFSET  = 7'd2;

    typedef logic alu_op_t;
    localparam alu_op_t ALU_ADD = 1'b0;
    localparam alu_op_t ALU_SUB = 1'b1;

    typedef struct packed {
        logic                valid;
        logic [OUT_BITS-1:0] average;
    } res_t;

endpackage

FILE: rtl/tma_alu.sv
// shared add/subtract unit, top bit is carry or borrow
module tma_alu
    import tma_pkg::*;
#(
    parameter int WIDTH = SAMPLE_BITS_DEF + CNT_BITS
)
(
    input  alu_op_t          op,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH:0]   y
);

    always_comb
    begin
        case (op)
            ALU_ADD: y = {1'b0, a} + {1'b0, b};
            ALU_SUB: y = {1'b0, a} - {1'b0, b};
            default: y = {1'b0, a} + {1'b0, b};
        endcase
    end

endmodule

FILE: rtl/tma_core.sv
// sequencer and batch registers driving the shared alu
module tma_core
    import tma_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [CNT_BITS-1:0]    batch_size,
    input  logic                   res_ready,
    output res_t                   res
);

    localparam int SUM_W     = SAMPLE_BITS + CNT_BITS;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ADD      = 3'd1;
    localparam logic [2:0] S_CMP_MAX  = 3'd2;
    localparam logic [2:0] S_CMP_MIN  = 3'd3;
    localparam logic [2:0] S_TRIM_MAX = 3'd4;
    localparam logic [2:0] S_TRIM_MIN = 3'd5;
    localparam logic [2:0] S_DIV      = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0]             state_reg, state_next;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [CNT_BITS-1:0]    rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;

    alu_op_t                alu_op;
    logic [SUM_W-1:0]       alu_a;
    logic [SUM_W-1:0]       alu_b;
    logic [SUM_W:0]         alu_y;
    logic                   alu_borrow;

    logic [CNT_BITS-1:0]    eff_batch;
    logic [CNT_BITS-1:0]    divisor;
    logic [CNT_BITS-1:0]    count_inc;
    logic                   batch_done;
    logic [CNT_BITS:0]      rem_shift;

    tma_alu #(
        .WIDTH (SUM_W)
    ) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    assign alu_borrow = alu_y[SUM_W];
    assign eff_batch  = (batch_size < BATCH_MIN) ? BATCH_MIN : batch_size;
    assign divisor    = eff_batch - DIV_OFFSET;
    assign count_inc  = count_reg + CNT_BITS'(1);
    assign batch_done = (count_inc >= eff_batch) || (count_inc == '0);
    assign rem_shift  = {rem_reg, sum_reg[SUM_W-1]};

    assign in_ready    = (state_reg == S_IDLE);
    assign res.valid   = (state_reg == S_DONE);
    assign res.average = sum_reg[OUT_BITS-1:0];

    // operand select for the shared unit
    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = sum_reg;
        alu_b  = SUM_W'(sample_reg);
        case (state_reg)
            S_CMP_MAX:
            begin
                alu_op = ALU_SUB;
                alu_a  = SUM_W'(max_reg);
                alu_b  = SUM_W'(sample_reg);
            end
            S_CMP_MIN:
            begin
                alu_op = ALU_SUB;
                alu_a  = SUM_W'(sample_reg);
                alu_b  = SUM_W'(min_reg);
            end
            S_TRIM_MAX:
            begin
                alu_op = ALU_SUB;
                alu_b  = SUM_W'(max_reg);
            end
            S_TRIM_MIN:
            begin
                alu_op = ALU_SUB;
                alu_b  = SUM_W'(min_reg);
            end
            S_DIV:
            begin
                alu_op = ALU_SUB;
                alu_a  = SUM_W'(rem_shift);
                alu_b  = SUM_W'(divisor);
            end
            default:
            begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        sample_next  = sample_reg;
        sum_next     = sum_reg;
        max_next     = max_reg;
        min_next     = min_reg;
        count_next   = count_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = sample;
                    state_next  = S_ADD;
                end
            end
            S_ADD:
            begin
                sum_next = alu_y[SUM_W-1:0];
                // first sample of a batch seeds both extremes
                if (count_reg == '0)
                begin
                    max_next = sample_reg;
                    min_next = sample_reg;
                end
                state_next = S_CMP_MAX;
            end
            S_CMP_MAX:
            begin
                if (alu_borrow)
                begin
                    max_next = sample_reg;
                end
                state_next = S_CMP_MIN;
            end
            S_CMP_MIN:
            begin
                if (alu_borrow)
                begin
                    min_next = sample_reg;
                end
                count_next = count_inc;
                state_next = batch_done ? S_TRIM_MAX : S_IDLE;
            end
            S_TRIM_MAX:
            begin
                sum_next   = alu_y[SUM_W-1:0];
                state_next = S_TRIM_MIN;
            end
            S_TRIM_MIN:
            begin
                sum_next     = alu_y[SUM_W-1:0];
                rem_next     = '0;
                div_cnt_next = DIV_CNT_W'(SUM_W);
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                // restoring division, quotient shifts into the sum register
                sum_next     = {sum_reg[SUM_W-2:0], ~alu_borrow};
                rem_next     = alu_borrow ? rem_shift[CNT_BITS-1:0] : alu_y[CNT_BITS-1:0];
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    sum_next   = '0;
                    max_next   = '0;
                    min_next   = '0;
                    count_next = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sum_reg     <= '0;
            max_reg     <= '0;
            min_reg     <= '0;
            count_reg   <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            max_reg     <= max_next;
            min_reg     <= min_next;
            count_reg   <= count_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        rem_reg    <= rem_next;
    end

endmodule

FILE: rtl/trimmed_mean_averager.sv
// top level of the trimmed mean averager: stream ports, batch size register, output register
//
//  channel   | signals                          | content
//  ----------+----------------------------------+------------------------------
//  input     | s_tvalid s_tready s_tdata[15:0]  | sample in [11:0]
//  output    | m_tvalid m_tready m_tdata[15:0]  | average in [11:0]
//  config    | cfg_valid cfg_ready cfg_data[7:0]| batch_size in [6:0]
//
//  a sample that does not close its batch passes the add and the two compare states of the shared alu
//  a sample that closes the batch then trims the max and the min and runs the
//  one-bit-per-cycle restoring division in the same alu
//  the result sits in an output register; the next sample is taken while it waits
//  a new result stalls in the core until the output register is free
//  rst_n clears the batch state and loads batch_size with 100
module trimmed_mean_averager
    import tma_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // [11:0] sample
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,   // [11:0] average
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data   // [6:0] batch_size
);

    logic [CNT_BITS-1:0]            batch_reg;
    logic [SAMPLE_BITS+IN_BITS-1:0] sample_ext;
    logic [SAMPLE_BITS-1:0]         sample_val;
    logic                           res_ready;
    res_t                           res;
    logic                           m_tvalid_reg;
    logic [OUT_BITS-1:0]            m_tdata_reg;

    assign sample_ext = {{SAMPLE_BITS{1'b0}}, s_tdata[IN_BITS-1:0]};
    assign sample_val = sample_ext[SAMPLE_BITS-1:0];

    assign cfg_ready = 1'b1;
    assign res_ready = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = OUT_TDATA_BITS'(m_tdata_reg);

    tma_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .sample     (sample_val),
        .batch_size (batch_reg),
        .res_ready  (res_ready),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_reg <= BATCH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            batch_reg <= cfg_data[CNT_BITS-1:0];
        end
    end

    // output register, refilled in the same cycle it drains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res.valid && res_ready)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_ready)
        begin
            m_tdata_reg <= res.average;
        end
    end

endmodule

FILE: rtl/tma_checker.sv
// port-level checks for the trimmed mean averager and their bind
module tma_checker
    import tma_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [OUT_TDATA_BITS-1:0] m_tdata
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one sample at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on back-to-back cycles");

    // a new result never appears right after a sample transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result raised right after an input transfer");

    // padding above the average stays zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_TDATA_BITS-1:OUT_BITS] == '0)
        else $error("output padding not zero");

endmodule

bind trimmed_mean_averager tma_checker u_tma_checker (.*);

FILE: tb/trimmed_mean_averager_checker.sv
// stream checker for the trimmed mean averager: predicts batch averages and compares transfers
`timescale 1ns / 100ps

module trimmed_mean_averager_checker
    import tma_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // [11:0] sample
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [OUT_TDATA_BITS-1:0] m_tdata,   // [11:0] average
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,  // [6:0] batch_size
    output int unsigned               outstanding,
    output int                        failures
);

    localparam int SUM_BITS = IN_BITS + CNT_BITS;

    logic [CNT_BITS-1:0] batch_len;
    logic [SUM_BITS-1:0] sum_acc;
    logic [IN_BITS-1:0]  peak;
    logic [IN_BITS-1:0]  trough;
    logic [CNT_BITS-1:0] held;
    logic [OUT_BITS-1:0] pending_averages[$];

    function automatic logic fold_sample(input logic [IN_BITS-1:0] sample,
                                         output logic [OUT_BITS-1:0] average);
        logic [CNT_BITS-1:0] span;
        logic [SUM_BITS-1:0] trimmed;
        span = (batch_len < BATCH_MIN) ? BATCH_MIN : batch_len;
        sum_acc = sum_acc + SUM_BITS'(sample);
        if (held == '0)
        begin
            peak   = sample;
            trough = sample;
        end
        else
        begin
            if (sample > peak)
                peak = sample;
            if (sample < trough)
                trough = sample;
        end
        held = held + CNT_BITS'(1);
        average = '0;
        if (held >= span || held == '0)
        begin
            trimmed = sum_acc - SUM_BITS'(peak) - SUM_BITS'(trough);
            average = OUT_BITS'(trimmed / SUM_BITS'(span - DIV_OFFSET));
            sum_acc = '0;
            peak    = '0;
            trough  = '0;
            held    = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        logic [OUT_BITS-1:0] want;
        logic [OUT_BITS-1:0] got;
        if (!rst_n)
        begin
            batch_len = BATCH_RESET;
            sum_acc   = '0;
            peak      = '0;
            trough    = '0;
            held      = '0;
            pending_averages.delete();
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[OUT_BITS-1:0];
                if (pending_averages.size() == 0)
                begin
                    $error("average: transfer with nothing expected, actual %0d", got);
                    failures = failures + 1;
                end
                else
                begin
                    want = pending_averages.pop_front();
                    if (got !== want)
                    begin
                        $error("average mismatch: expected %0d, actual %0d", want, got);
                        failures = failures + 1;
                    end
                end
                if (m_tdata[OUT_TDATA_BITS-1:OUT_BITS] !== '0)
                begin
                    $error("m_tdata pad mismatch: expected 0, actual %0h",
                           m_tdata[OUT_TDATA_BITS-1:OUT_BITS]);
                    failures = failures + 1;
                end
            end
            if (cfg_valid && cfg_ready)
                batch_len = cfg_data[CNT_BITS-1:0];
            if (s_tvalid && s_tready)
            begin
                if (fold_sample(s_tdata[IN_BITS-1:0], want))
                    pending_averages.push_back(want);
            end
            outstanding = pending_averages.size();
        end
    end

endmodule

FILE: tb/trimmed_mean_averager_tb.sv
// testbench top for the trimmed mean averager: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module trimmed_mean_averager_tb;
    import tma_pkg::*;

    localparam int RANDOM_ITEMS  = 1500;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata   = '0;   // [11:0] sample
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;          // [11:0] average
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;   // [6:0] batch_size

    int unsigned outstanding;
    int          failures;
    int unsigned hold_requests  = 0;
    bit          sender_idles   = 1'b1;
    bit          receiver_idles = 1'b1;

    trimmed_mean_averager dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    trimmed_mean_averager_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .failures    (failures)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("trimmed_mean_averager_tb: errors");
        $finish;
    end

    task automatic send_sample(input logic [IN_BITS-1:0] value);
        int gap;
        gap = sender_idles ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_BITS-IN_BITS){1'b0}}, value};
        do @(posedge clk); while (!(s_tvalid && s_tready));
    endtask

    // stop sending and wait until every average has come out and the core is quiet
    task automatic drain_block();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_batch(input logic [CNT_BITS-1:0] len);
        drain_block();
        cfg_valid <= 1'b1;
        cfg_data  <= {{(CFG_DATA_BITS-CNT_BITS){1'b0}}, len};
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : receiver
        int          gap;
        int unsigned holds_served;
        holds_served = 0;
        @(posedge rst_n);
        forever
        begin
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = receiver_idles ? $urandom_range(0, 7) : 0;
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    initial
    begin : stimulus
        int                  sent;
        int                  phase;
        int                  pick;
        int                  eff;
        int                  count;
        int                  style;
        logic [CNT_BITS-1:0] len;
        logic [IN_BITS-1:0]  base;
        logic [IN_BITS-1:0]  value;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // partial batch at the reset size, then shrink it so the next sample closes
        repeat (5) send_sample(12'hFFF);
        write_batch(7'd3);
        send_sample(12'hFFF);

        send_sample(12'h000);
        send_sample(12'hFFF);
        send_sample(12'h800);
        repeat (3) send_sample(12'hFFF);
        repeat (3) send_sample(12'h000);

        // sizes below the minimum
        write_batch(7'd0);
        send_sample(12'd1);
        send_sample(12'd2);
        send_sample(12'd3);
        write_batch(7'd2);
        send_sample(12'hAAA);
        send_sample(12'h555);
        send_sample(12'hFFF);
        write_batch(7'd1);
        repeat (3) send_sample(12'd7);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase = phase + 1;
            pick  = $urandom_range(0, 9);
            if (phase == 1)
                len = 7'd3;
            else if (pick == 0)
                len = CNT_BITS'($urandom_range(0, 2));
            else if (pick == 1)
                len = 7'd127;
            else if (pick < 4)
                len = CNT_BITS'($urandom_range(17, 126));
            else
                len = CNT_BITS'($urandom_range(3, 16));
            write_batch(len);

            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            eff = (len < BATCH_MIN) ? int'(BATCH_MIN) : int'(len);
            if (phase == 1)
            begin
                sender_idles  = 1'b0;
                hold_requests = hold_requests + 1;
                count = 60;
            end
            else
            begin
                if ($urandom_range(0, 11) == 0)
                    hold_requests = hold_requests + 1;
                count = eff * $urandom_range(1, (eff > 40) ? 1 : 6)
                      + $urandom_range(0, eff - 1);
            end

            style = $urandom_range(0, 3);
            base  = IN_BITS'($urandom_range(0, 4095 - 15));
            repeat (count)
            begin
                case (style)
                    0: value = IN_BITS'($urandom_range(0, 4095));
                    1:
                    begin
                        case ($urandom_range(0, 4))
                            0: value = 12'h000;
                            1: value = 12'hFFF;
                            2: value = 12'h001;
                            3: value = 12'hFFE;
                            default: value = IN_BITS'($urandom_range(0, 4095));
                        endcase
                    end
                    2: value = base + IN_BITS'($urandom_range(0, 15));
                    default: value = ($urandom_range(0, 3) == 0)
                                   ? IN_BITS'($urandom_range(0, 4095)) : base;
                endcase
                send_sample(value);
            end
            sent = sent + count;
        end

        drain_block();
        if (failures == 0)
            $display("trimmed_mean_averager_tb: clean");
        else
            $display("trimmed_mean_averager_tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/tma_pkg.sv
rtl/tma_alu.sv
rtl/tma_core.sv
rtl/trimmed_mean_averager.sv
rtl/tma_checker.sv
tb/trimmed_mean_averager_checker.sv
tb/trimmed_mean_averager_tb.sv
